[hw/rtl/hsc_pkg.sv]
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared widths, register index and code-geometry functions for the
// Hamming single-error-correcting codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

    localparam int WORD_W   = 31;
    localparam int DL_W     = 5;
    localparam int LEN_W    = 6;
    localparam int POS_W    = 5;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int DL_MAX   = 31;

    localparam logic [DL_W-1:0] DATA_LEN_RST = 5'd4;

    typedef enum logic {
        REG_DATA_LEN = 1'b0,
        REG_NONE     = 1'b1
    } t_reg_idx;

    typedef enum logic {
        KIND_ENCODE = 1'b0,
        KIND_DECODE = 1'b1
    } t_kind;

    function automatic int parity_count(input int k);
        int p;
        p = 0;
        for (int i = 0; i < 7; i++) begin
            if ((1 << p) < k + p + 1) begin
                p = p + 1;
            end
        end
        return p;
    endfunction

    function automatic int code_len(input int dl, input int kmax);
        int k;
        k = dl;
        if (k < 1) begin
            k = 1;
        end
        if (k > kmax) begin
            k = kmax;
        end
        return k + parity_count(k);
    endfunction

    function automatic bit is_pow2(input int v);
        return (v != 0) && ((v & (v - 1)) == 0);
    endfunction

    // index of the data bit held at a non-parity position
    function automatic int data_index(input int pos);
        int j;
        j = 0;
        for (int q = 1; q < pos; q++) begin
            if (!is_pow2(q)) begin
                j = j + 1;
            end
        end
        return j;
    endfunction

endpackage

[hw/rtl/hsc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// hsc_cfg_regs
// APB register file holding the data length, with the code length
// derived at write time.
// ----------------------------------------------------------------------------
module hsc_cfg_regs import hsc_pkg::*; #(
    parameter int MAX_DATA_BITS = 26
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    output logic [LEN_W-1:0]     o_code_len
);

    logic [DL_W-1:0]  r_data_len;
    logic [DL_W-1:0]  n_data_len;
    logic [LEN_W-1:0] r_code_len;
    logic [LEN_W-1:0] n_code_len;
    logic             wr_en;
    t_reg_idx         reg_idx;

    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_DATA_LEN);

    always_comb begin
        n_data_len = r_data_len;
        n_code_len = r_code_len;
        if (wr_en) begin
            n_data_len = pwdata[DL_W-1:0];
            n_code_len = LEN_W'(code_len(int'(pwdata[DL_W-1:0]), MAX_DATA_BITS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_len <= DATA_LEN_RST;
            r_code_len <= LEN_W'(code_len(int'(DATA_LEN_RST), MAX_DATA_BITS));
        end else begin
            r_data_len <= n_data_len;
            r_code_len <= n_code_len;
        end
    end

    assign prdata     = (reg_idx == REG_DATA_LEN) ? APB_DW'(r_data_len) : '0;
    assign pready     = 1'b1;
    assign o_code_len = r_code_len;

endmodule

[hw/rtl/hsc_codec.sv]
// ----------------------------------------------------------------------------
// hsc_codec
// Combinational encode and decode: data spreading, syndrome tree,
// parity insertion and single-bit correction.
// ----------------------------------------------------------------------------
module hsc_codec import hsc_pkg::*; #(
    parameter int CW_W = 31,
    parameter int S_W  = 5
) (
    input  logic              i_kind,
    input  logic [WORD_W-1:0] i_word,
    input  logic [LEN_W-1:0]  i_code_len,
    output logic [WORD_W-1:0] o_codeword,
    output logic              o_error_found,
    output logic [POS_W-1:0]  o_error_position,
    output logic              o_position_invalid
);

    logic [CW_W-1:0] spread;
    logic [CW_W-1:0] nmask;
    logic [CW_W-1:0] base;
    logic [CW_W-1:0] par_bits;
    logic [CW_W-1:0] flip;
    logic [CW_W-1:0] cw;
    logic [S_W-1:0]  syn;
    logic            found;
    logic            invalid;
    logic            is_dec;

    // data bits fill the non-power-of-two positions in order
    for (genvar b = 0; b < CW_W; b++) begin : g_spread
        localparam int J = data_index(b + 1);
        if (is_pow2(b + 1) || (J >= WORD_W)) begin : g_zero
            assign spread[b] = 1'b0;
        end else begin : g_data
            assign spread[b] = i_word[J];
        end
    end

    assign is_dec = (t_kind'(i_kind) == KIND_DECODE);

    always_comb begin
        for (int b = 0; b < CW_W; b++) begin
            nmask[b] = (LEN_W'(b) < i_code_len);
        end
        base = is_dec ? (CW_W'(i_word) & nmask) : (spread & nmask);

        syn = '0;
        for (int b = 0; b < CW_W; b++) begin
            if (base[b]) begin
                syn = syn ^ S_W'(b + 1);
            end
        end

        for (int b = 0; b < CW_W; b++) begin
            par_bits[b] = is_pow2(b + 1) && (|(syn & S_W'(b + 1)));
            flip[b]     = (syn == S_W'(b + 1));
        end

        found   = (syn != '0);
        invalid = found && (LEN_W'(syn) > i_code_len);

        if (is_dec) begin
            cw = (found && !invalid) ? (base ^ flip) : base;
        end else begin
            cw = base | par_bits;
        end
    end

    assign o_codeword         = cw[WORD_W-1:0];
    assign o_error_found      = is_dec && found;
    assign o_error_position   = is_dec ? syn[POS_W-1:0] : '0;
    assign o_position_invalid = is_dec && invalid;

endmodule

[hw/rtl/hamming_sec_codec_core.sv]
// ----------------------------------------------------------------------------
// hamming_sec_codec_core
// Hamming single-error-correcting encoder/decoder with even parity.
// Path: an input register, loaded at acceptance, then a result register,
// loaded once the result side has room. Throughput: one request per cycle
// unless the result side stalls, set by single-pass parity/syndrome logic.
// Reset: synchronous active low, clears both stage valids, data_len = 4.
// ----------------------------------------------------------------------------
module hamming_sec_codec_core import hsc_pkg::*; #(
    parameter int MAX_DATA_BITS = 26
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic [WORD_W-1:0]    i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [WORD_W-1:0]    o_codeword,
    output logic                 o_error_found,
    output logic [POS_W-1:0]     o_error_position,
    output logic                 o_position_invalid,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int N_MAX = code_len(DL_MAX, MAX_DATA_BITS);
    localparam int CW_W  = (N_MAX > WORD_W) ? N_MAX : WORD_W;
    localparam int S_W   = $clog2(CW_W + 1);

    logic [LEN_W-1:0]  code_len_q;
    logic              r_in_valid;
    logic              n_in_valid;
    logic              r_kind;
    logic [WORD_W-1:0] r_word;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [WORD_W-1:0] r_codeword;
    logic              r_error_found;
    logic [POS_W-1:0]  r_error_position;
    logic              r_position_invalid;
    logic [WORD_W-1:0] c_codeword;
    logic              c_error_found;
    logic [POS_W-1:0]  c_error_position;
    logic              c_position_invalid;
    logic              in_take;
    logic              s1_ready;
    logic              s1_move;

    hsc_cfg_regs #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_code_len (code_len_q)
    );

    hsc_codec #(
        .CW_W (CW_W),
        .S_W  (S_W)
    ) u_codec (
        .i_kind             (r_kind),
        .i_word             (r_word),
        .i_code_len         (code_len_q),
        .o_codeword         (c_codeword),
        .o_error_found      (c_error_found),
        .o_error_position   (c_error_position),
        .o_position_invalid (c_position_invalid)
    );

    assign s1_ready = !r_out_valid || i_ready;
    assign o_ready  = !r_in_valid || s1_ready;
    assign in_take  = i_valid && o_ready;
    assign s1_move  = r_in_valid && s1_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (s1_move) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (s1_move) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind <= i_kind;
            r_word <= i_word;
        end
        if (s1_move) begin
            r_codeword         <= c_codeword;
            r_error_found      <= c_error_found;
            r_error_position   <= c_error_position;
            r_position_invalid <= c_position_invalid;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_codeword         = r_codeword;
    assign o_error_found      = r_error_found;
    assign o_error_position   = r_error_position;
    assign o_position_invalid = r_position_invalid;

endmodule

[tb/sv/hamming_sec_codec_core_test.sv]
// ----------------------------------------------------------------------------
// hamming_sec_codec_core_test
// Self-checking bench for the Hamming single-error-correcting codec. Requests
// go in on a valid/ready channel with random gaps. Each one is predicted in
// the bench from the current data length, and each result is checked against
// the oldest prediction while the result side stalls at random. The data
// length is changed over APB between phases, once the block has drained.
// ----------------------------------------------------------------------------
module hamming_sec_codec_core_test import hsc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_K    = 26;
    localparam int TAIL     = 8;
    localparam int PHASES   = 14;
    localparam int PER_PASS = 100;

    typedef struct packed {
        logic [WORD_W-1:0] codeword;
        logic              error_found;
        logic [POS_W-1:0]  error_position;
        logic              position_invalid;
    } t_codec_result;

    class hamming_checker;
        logic [DL_W-1:0] data_len;
        t_codec_result   awaited[$];
        int              mismatches;

        function new();
            data_len   = DATA_LEN_RST;
            mismatches = 0;
        endfunction

        function void geometry(output int k, output int p, output int n);
            k = int'(data_len);
            if (k < 1) begin
                k = 1;
            end
            if (k > MAX_K) begin
                k = MAX_K;
            end
            p = 0;
            while ((1 << p) < k + p + 1) begin
                p++;
            end
            n = k + p;
        endfunction

        function int syndrome(logic [WORD_W-1:0] cw, int n);
            int s;
            s = 0;
            for (int pos = 1; pos <= n; pos++) begin
                if (cw[pos-1]) begin
                    s = s ^ pos;
                end
            end
            return s;
        endfunction

        function t_codec_result predict_codec(t_kind kind, logic [WORD_W-1:0] word);
            int k, p, n, j, syn;
            t_codec_result r;
            geometry(k, p, n);
            r = '0;
            if (kind == KIND_ENCODE) begin
                j = 0;
                for (int pos = 1; pos <= n; pos++) begin
                    if ((pos & (pos - 1)) != 0) begin
                        r.codeword[pos-1] = word[j];
                        j++;
                    end
                end
                syn = syndrome(r.codeword, n);
                for (int i = 0; i < p; i++) begin
                    if (syn[i]) begin
                        r.codeword[(1 << i) - 1] = 1'b1;
                    end
                end
            end else begin
                for (int pos = 1; pos <= n; pos++) begin
                    r.codeword[pos-1] = word[pos-1];
                end
                syn = syndrome(r.codeword, n);
                if (syn != 0) begin
                    r.error_found    = 1'b1;
                    r.error_position = syn[POS_W-1:0];
                    if (syn > n) begin
                        r.position_invalid = 1'b1;
                    end else begin
                        r.codeword[syn-1] = ~r.codeword[syn-1];
                    end
                end
            end
            return r;
        endfunction

        function void note_request(t_kind kind, logic [WORD_W-1:0] word);
            awaited.push_back(predict_codec(kind, word));
        endfunction

        function void check_result(t_codec_result got);
            t_codec_result want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual codeword %h",
                         $time, got.codeword);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.codeword !== want.codeword) begin
                $display("%0t: codeword expected %h actual %h",
                         $time, want.codeword, got.codeword);
                mismatches++;
            end
            if (got.error_found !== want.error_found) begin
                $display("%0t: error_found expected %b actual %b",
                         $time, want.error_found, got.error_found);
                mismatches++;
            end
            if (got.error_position !== want.error_position) begin
                $display("%0t: error_position expected %0d actual %0d",
                         $time, want.error_position, got.error_position);
                mismatches++;
            end
            if (got.position_invalid !== want.position_invalid) begin
                $display("%0t: position_invalid expected %b actual %b",
                         $time, want.position_invalid, got.position_invalid);
                mismatches++;
            end
        endfunction
    endclass

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic              i_kind  = 1'b0;
    logic [WORD_W-1:0] i_word  = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [WORD_W-1:0] o_codeword;
    logic              o_error_found;
    logic [POS_W-1:0]  o_error_position;
    logic              o_position_invalid;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bit                calm = 1'b0;
    hamming_checker    sb;

    hamming_sec_codec_core #(
        .MAX_DATA_BITS(MAX_K)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_kind             (i_kind),
        .i_word             (i_word),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_codeword         (o_codeword),
        .o_error_found      (o_error_found),
        .o_error_position   (o_error_position),
        .o_position_invalid (o_position_invalid),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, 6));
    endfunction

    task automatic send_request(t_kind kind, logic [WORD_W-1:0] word);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_word  <= word;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        sb.note_request(kind, word);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(idx));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DATA_LEN) begin
            sb.data_len = value[DL_W-1:0];
        end
    endtask

    task automatic change_data_len(logic [DL_W-1:0] len);
        i_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        write_reg(REG_DATA_LEN, {(APB_DW - DL_W)'($urandom()), len});
    endtask

    task automatic send_random_item();
        int k, p, n, pick, a;
        logic [WORD_W-1:0] w;
        t_codec_result enc;
        sb.geometry(k, p, n);
        pick = $urandom_range(0, 99);
        w    = WORD_W'($urandom());
        if (pick < 35) begin
            send_request(KIND_ENCODE, w);
        end else if (pick < 90) begin
            enc = sb.predict_codec(KIND_ENCODE, w);
            // stray bits above the code length now and then
            if ($urandom_range(0, 3) == 0) begin
                enc.codeword = enc.codeword | (WORD_W'($urandom()) << n);
            end
            a = $urandom_range(0, n);
            if (pick >= 80) begin
                // double error
                a = $urandom_range(1, n);
                enc.codeword[(a % n)] = ~enc.codeword[(a % n)];
            end
            if (a != 0) begin
                enc.codeword[a-1] = ~enc.codeword[a-1];
            end
            send_request(KIND_DECODE, enc.codeword);
        end else begin
            send_request(KIND_DECODE, w);
        end
    endtask

    initial begin : result_sink
        int stall;
        t_codec_result got;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            got = '{o_codeword, o_error_found, o_error_position, o_position_invalid};
            sb.check_result(got);
        end
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int fixed_lens[10];
        int len;
        t_codec_result enc;
        sb = new();
        fixed_lens = '{4, 1, 26, 0, 31, 2, 3, 5, 12, 27};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset data length
        send_request(KIND_ENCODE, '0);
        send_request(KIND_ENCODE, 31'h0000_000F);
        send_request(KIND_ENCODE, 31'h7FFF_FFF0);
        send_request(KIND_DECODE, '0);
        send_request(KIND_DECODE, 31'h0000_007F);
        send_request(KIND_DECODE, 31'h7FFF_FF80);

        change_data_len(5'd26);
        send_request(KIND_ENCODE, 31'h03FF_FFFF);
        send_request(KIND_ENCODE, 31'h7FFF_FFFF);
        send_request(KIND_DECODE, 31'h7FFF_FFFF);
        send_request(KIND_DECODE, 31'h4000_0000);
        enc = sb.predict_codec(KIND_ENCODE, 31'h02AA_AAAA);
        send_request(KIND_DECODE, enc.codeword ^ 31'h0000_0001);
        send_request(KIND_DECODE, enc.codeword ^ 31'h4000_0000);

        // syndrome beyond the code length
        change_data_len(5'd2);
        send_request(KIND_DECODE, 31'h0000_000A);
        send_request(KIND_DECODE, 31'h0000_0014);
        send_request(KIND_DECODE, 31'h7FFF_FFFF);
        send_request(KIND_ENCODE, 31'h0000_0003);

        change_data_len(5'd0);
        send_request(KIND_ENCODE, 31'h7FFF_FFFF);
        send_request(KIND_DECODE, 31'h0000_0004);

        change_data_len(5'd31);
        send_request(KIND_ENCODE, 31'h5555_5555);
        send_request(KIND_DECODE, 31'h2AAA_AAAA);

        for (int ph = 0; ph < PHASES; ph++) begin
            len = (ph < 10) ? fixed_lens[ph] : int'($urandom_range(0, 31));
            change_data_len(DL_W'(len));
            calm = ($urandom_range(0, 3) == 0);
            repeat (PER_PASS) send_random_item();
        end

        i_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[hamming_sec_codec_core.f]
hw/rtl/hsc_pkg.sv
hw/rtl/hsc_cfg_regs.sv
hw/rtl/hsc_codec.sv
hw/rtl/hamming_sec_codec_core.sv
tb/sv/hamming_sec_codec_core_test.sv
